FILE: src/kpi_pkg.sv
// Shared types and constants for the keyframe pose interpolator.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package kpi_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_LOOP   = 2'd0;
   localparam logic [1:0] CSR_PERIOD = 2'd1;
   localparam logic [1:0] CSR_COUNT  = 2'd2;

   // output field order through the shared multiplier
   localparam logic [2:0] FLD_X     = 3'd0;
   localparam logic [2:0] FLD_Y     = 3'd1;
   localparam logic [2:0] FLD_Z     = 3'd2;
   localparam logic [2:0] FLD_ROLL  = 3'd3;
   localparam logic [2:0] FLD_PITCH = 3'd4;
   localparam logic [2:0] FLD_YAW   = 3'd5;

   // multiply sequence phases for one field
   localparam logic [2:0] MP_ABS   = 3'd0;
   localparam logic [2:0] MP_LO    = 3'd1;
   localparam logic [2:0] MP_HI    = 3'd2;
   localparam logic [2:0] MP_ACC   = 3'd3;
   localparam logic [2:0] MP_ROUND = 3'd4;

   // divider step counts (last step index)
   localparam logic [4:0] MOD_LAST_STEP   = 5'd31;
   localparam logic [4:0] RATIO_LAST_STEP = 5'd29;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SLOT, ST_END, ST_MODE, ST_MOD, ST_MODFIX, ST_SCMP, ST_RDA,
      ST_RDB, ST_PREP, ST_RSEL, ST_DIV, ST_DIVEND, ST_MUL, ST_OUT
   } kpi_state_type;

   typedef struct packed {
      logic       load_wr;
      logic       take_query;
      logic       slot_latch;
      logic       end_latch;
      logic       t_now;
      logic       mod_start;
      logic       ratio_start;
      logic       div_step;
      logic       mod_fix;
      logic       latch_a;
      logic       latch_b;
      logic       prep;
      logic       ratio_zero;
      logic       ratio_one;
      logic       ratio_quo;
      logic       mul_en;
      logic [2:0] mul_phase;
      logic [2:0] field;
      logic       out_load;
   } kpi_cmd_type;

   typedef struct packed {
      logic req_mode;
      logic rate_pass;
      logic n_is_one;
      logic loop_on;
      logic past_end;
      logic hit;
      logic el_le0;
      logic el_ge_dur;
      logic rsp_free;
   } kpi_status_type;

endpackage
`default_nettype wire

FILE: src/kpi_ctrl.sv
// Controller for the keyframe pose interpolator: sequences load, rate check,
// wrap, segment search, ratio division and per-field multiply. Uses kpi_pkg.
`default_nettype none
module kpi_ctrl
   import kpi_pkg::*;
#(
   parameter int AW = 6
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   input  wire kpi_status_type status,
   input  wire logic [AW-1:0]  last_idx,
   output      kpi_cmd_type    cmd,
   output      logic [AW-1:0]  rd_addr
);

   localparam logic [AW-1:0] ONE = {{(AW-1){1'b0}}, 1'b1};

   kpi_state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [2:0]    field_ff, field_in;
   logic [2:0]    phase_ff, phase_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         field_ff <= FLD_X;
         phase_ff <= MP_ABS;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         field_ff <= field_in;
         phase_ff <= phase_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      field_in      = field_ff;
      phase_in      = phase_ff;
      cmd           = '0;
      cmd.mul_phase = phase_ff;
      cmd.field     = field_ff;
      rd_addr       = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!status.req_mode) begin
                  cmd.load_wr = 1'b1;
               end else if (status.rate_pass) begin
                  cmd.take_query = 1'b1;
                  if (status.n_is_one) begin
                     rd_addr  = '0;
                     state_in = ST_SLOT;
                  end else begin
                     rd_addr  = last_idx;
                     state_in = ST_END;
                  end
               end
            end
         end
         ST_SLOT: begin
            cmd.slot_latch = 1'b1;
            state_in       = ST_OUT;
         end
         ST_END: begin
            cmd.end_latch = 1'b1;
            state_in      = ST_MODE;
         end
         ST_MODE: begin
            if (status.loop_on) begin
               cmd.mod_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_MOD;
            end else if (status.past_end) begin
               rd_addr  = last_idx;
               state_in = ST_SLOT;
            end else begin
               cmd.t_now = 1'b1;
               idx_in    = ONE;
               rd_addr   = ONE;
               state_in  = ST_SCMP;
            end
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == MOD_LAST_STEP) state_in = ST_MODFIX;
         end
         ST_MODFIX: begin
            cmd.mod_fix = 1'b1;
            idx_in      = ONE;
            rd_addr     = ONE;
            state_in    = ST_SCMP;
         end
         // one table entry compared per cycle, next address issued alongside
         ST_SCMP: begin
            if (status.hit) begin
               rd_addr  = idx_ff - ONE;
               state_in = ST_RDA;
            end else if (idx_ff == last_idx) begin
               rd_addr  = last_idx;
               state_in = ST_SLOT;
            end else begin
               idx_in  = idx_ff + ONE;
               rd_addr = idx_ff + ONE;
            end
         end
         ST_RDA: begin
            cmd.latch_a = 1'b1;
            rd_addr     = idx_ff;
            state_in    = ST_RDB;
         end
         ST_RDB: begin
            cmd.latch_b = 1'b1;
            state_in    = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_RSEL;
         end
         ST_RSEL: begin
            field_in = FLD_X;
            phase_in = MP_ABS;
            if (status.el_le0) begin
               cmd.ratio_zero = 1'b1;
               state_in       = ST_MUL;
            end else if (status.el_ge_dur) begin
               cmd.ratio_one = 1'b1;
               state_in      = ST_MUL;
            end else begin
               cmd.ratio_start = 1'b1;
               cnt_in          = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == RATIO_LAST_STEP) state_in = ST_DIVEND;
         end
         ST_DIVEND: begin
            cmd.ratio_quo = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (phase_ff == MP_ROUND) begin
               phase_in = MP_ABS;
               if (field_ff == FLD_YAW) begin
                  field_in = FLD_X;
                  state_in = ST_OUT;
               end else begin
                  field_in = field_ff + 3'd1;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/kpi_datapath.sv
// Datapath for the keyframe pose interpolator: waypoint memories, config
// registers, shared restoring divider, 17x31 multiplier and output register. Uses kpi_pkg.
`default_nettype none
module kpi_datapath
   import kpi_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 64,
   parameter int AW = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kpi_cmd_type        cmd,
   input  wire logic [AW-1:0]      rd_addr,
   output      kpi_status_type     status,
   output      logic [AW-1:0]      last_idx,
   input  wire logic               csr_fire,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_mode,
   input  wire logic [5:0]         req_entry_index,
   input  wire logic signed [31:0] req_time_value,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   input  wire logic signed [15:0] req_yaw_angle,
   input  wire logic               rsp_ready,
   output      logic               rsp_valid,
   output      logic signed [31:0] rsp_out_x,
   output      logic signed [31:0] rsp_out_y,
   output      logic signed [31:0] rsp_out_z,
   output      logic signed [15:0] rsp_out_roll,
   output      logic signed [15:0] rsp_out_pitch,
   output      logic signed [15:0] rsp_out_yaw,
   output      logic               rsp_held_at_end
);

   // waypoint tables
   logic [31:0] mem_t [MAX_WAYPOINTS];
   logic [31:0] mem_x [MAX_WAYPOINTS];
   logic [31:0] mem_y [MAX_WAYPOINTS];
   logic [31:0] mem_z [MAX_WAYPOINTS];
   logic [47:0] mem_a [MAX_WAYPOINTS];

   logic [31:0] rd_t_ff, rd_x_ff, rd_y_ff, rd_z_ff;
   logic [47:0] rd_a_ff;

   logic [31:0]   slot_full;
   logic [AW-1:0] wr_addr;
   logic          wr_ok;

   assign slot_full = 32'(req_entry_index);
   assign wr_addr   = slot_full[AW-1:0];
   assign wr_ok     = slot_full < 32'(MAX_WAYPOINTS);

   always_ff @(posedge clock) begin
      if (cmd.load_wr && wr_ok) begin
         mem_t[wr_addr] <= req_time_value;
         mem_x[wr_addr] <= req_pos_x;
         mem_y[wr_addr] <= req_pos_y;
         mem_z[wr_addr] <= req_pos_z;
         mem_a[wr_addr] <= {req_yaw_angle, req_pitch_angle, req_roll_angle};
      end
      rd_t_ff <= mem_t[rd_addr];
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_z_ff <= mem_z[rd_addr];
      rd_a_ff <= mem_a[rd_addr];
   end

   // configuration and rate-limit state
   logic        loop_ff;
   logic [31:0] period_ff;
   logic [6:0]  count_ff;
   logic [31:0] last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff   <= 1'b1;
         period_ff <= 32'd2185;
         count_ff  <= 7'd1;
         last_ff   <= '0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               CSR_LOOP:   loop_ff   <= csr_data[0];
               CSR_PERIOD: period_ff <= csr_data;
               CSR_COUNT:  count_ff  <= csr_data[6:0];
               default: ;
            endcase
         end
         if (cmd.take_query) last_ff <= req_time_value;
      end
   end

   // clamped waypoint count
   logic [31:0] n_full, n_m1;
   always_comb begin
      n_full = (count_ff == 7'd0) ? 32'd1 : 32'(count_ff);
      if (n_full > 32'(MAX_WAYPOINTS)) n_full = 32'(MAX_WAYPOINTS);
      n_m1 = n_full - 32'd1;
   end
   assign last_idx = n_m1[AW-1:0];

   // rate check: gap is exact signed difference
   logic signed [33:0] gap;
   assign gap = 34'(req_time_value) - 34'(signed'(last_ff));

   // query time, end time, wrapped time
   logic signed [31:0] now_ff, end_ff, t_ff;

   // shared restoring divider
   logic [31:0] rem_ff, quo_ff, div_ff;
   logic [32:0] trial;
   logic        take;
   assign trial = {rem_ff, quo_ff[31]};
   assign take  = trial >= {1'b0, div_ff};

   // segment endpoints
   logic [31:0] a_t_ff, a_x_ff, a_y_ff, a_z_ff;
   logic [47:0] a_a_ff;
   logic [31:0] b_t_ff, b_x_ff, b_y_ff, b_z_ff;
   logic [47:0] b_a_ff;

   logic signed [32:0] dur_raw, dur_clp, el_raw;
   logic [31:0] dur_ff, el_ff;
   logic        el_le0_ff, el_ge_ff;

   assign dur_raw = 33'(signed'(b_t_ff)) - 33'(signed'(a_t_ff));
   assign dur_clp = (dur_raw < 33'sd1) ? 33'sd1 : dur_raw;
   assign el_raw  = 33'(t_ff) - 33'(signed'(a_t_ff));

   always_ff @(posedge clock) begin
      if (cmd.take_query) now_ff <= req_time_value;
      if (cmd.end_latch) end_ff <= (signed'(rd_t_ff) < 32'sd1) ? 32'sd1 : rd_t_ff;
      if (cmd.t_now) t_ff <= now_ff;
      if (cmd.mod_fix) t_ff <= (now_ff[31] && rem_ff != 32'd0) ? end_ff - rem_ff : rem_ff;
      if (cmd.mod_start) begin
         rem_ff <= '0;
         quo_ff <= now_ff[31] ? 32'(-now_ff) : now_ff;
         div_ff <= end_ff;
      end else if (cmd.ratio_start) begin
         rem_ff <= el_ff;
         quo_ff <= '0;
         div_ff <= dur_ff;
      end else if (cmd.div_step) begin
         rem_ff <= take ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
         quo_ff <= {quo_ff[30:0], take};
      end
      if (cmd.latch_a) begin
         a_t_ff <= rd_t_ff; a_x_ff <= rd_x_ff; a_y_ff <= rd_y_ff;
         a_z_ff <= rd_z_ff; a_a_ff <= rd_a_ff;
      end
      if (cmd.latch_b) begin
         b_t_ff <= rd_t_ff; b_x_ff <= rd_x_ff; b_y_ff <= rd_y_ff;
         b_z_ff <= rd_z_ff; b_a_ff <= rd_a_ff;
      end
      if (cmd.prep) begin
         dur_ff    <= dur_clp[31:0];
         el_ff     <= el_raw[31:0];
         el_le0_ff <= el_raw <= 33'sd0;
         el_ge_ff  <= el_raw >= dur_clp;
      end
   end

   // per-field operands: start value and folded delta
   logic signed [32:0] f_val, d_val;
   logic signed [17:0] ang_d;
   logic [15:0]        ang_f, ang_b;
   always_comb begin
      ang_f = a_a_ff[15:0];
      ang_b = b_a_ff[15:0];
      case (cmd.field)
         FLD_PITCH: begin ang_f = a_a_ff[31:16]; ang_b = b_a_ff[31:16]; end
         FLD_YAW:   begin ang_f = a_a_ff[47:32]; ang_b = b_a_ff[47:32]; end
         default: ;
      endcase
      ang_d = 18'(signed'(ang_b)) - 18'(signed'(ang_f));
      if (ang_d > 18'sd32768) ang_d = ang_d - 18'sd65536;
      else if (ang_d < -18'sd32768) ang_d = ang_d + 18'sd65536;
      case (cmd.field)
         FLD_X: begin
            f_val = 33'(signed'(a_x_ff));
            d_val = 33'(signed'(b_x_ff)) - 33'(signed'(a_x_ff));
         end
         FLD_Y: begin
            f_val = 33'(signed'(a_y_ff));
            d_val = 33'(signed'(b_y_ff)) - 33'(signed'(a_y_ff));
         end
         FLD_Z: begin
            f_val = 33'(signed'(a_z_ff));
            d_val = 33'(signed'(b_z_ff)) - 33'(signed'(a_z_ff));
         end
         default: begin
            f_val = 33'(signed'(ang_f));
            d_val = 33'(ang_d);
         end
      endcase
   end

   // multiply sequence: |d| * ratio in two halves, then round and add
   logic [30:0] ratio_ff;
   logic [32:0] mag_ff;
   logic        neg_ff;
   logic signed [32:0] base_ff;
   logic [47:0] prod_ff;
   logic [63:0] acc_ff;
   logic [63:0] rnd;
   logic [34:0] q35, sum35;

   assign rnd   = acc_ff + 64'h2000_0000;
   assign q35   = {1'b0, rnd[63:30]};
   assign sum35 = neg_ff ? 35'(base_ff) - q35 : 35'(base_ff) + q35;

   logic signed [31:0] res_x_ff, res_y_ff, res_z_ff;
   logic signed [15:0] res_roll_ff, res_pitch_ff, res_yaw_ff;
   logic               res_held_ff;

   always_ff @(posedge clock) begin
      if (cmd.ratio_zero) ratio_ff <= '0;
      if (cmd.ratio_one) ratio_ff <= 31'h4000_0000;
      if (cmd.ratio_quo) ratio_ff <= {1'b0, quo_ff[29:0]};
      if (cmd.mul_en) begin
         case (cmd.mul_phase)
            MP_ABS: begin
               base_ff <= f_val;
               neg_ff  <= d_val[32];
               mag_ff  <= d_val[32] ? 33'(-d_val) : d_val;
            end
            MP_LO: prod_ff <= 48'(mag_ff[15:0] * ratio_ff);
            MP_HI: begin
               acc_ff  <= 64'(prod_ff);
               prod_ff <= 48'(mag_ff[32:16] * ratio_ff);
            end
            MP_ACC: acc_ff <= acc_ff + {prod_ff, 16'd0};
            MP_ROUND: begin
               res_held_ff <= 1'b0;
               case (cmd.field)
                  FLD_X:     res_x_ff     <= sum35[31:0];
                  FLD_Y:     res_y_ff     <= sum35[31:0];
                  FLD_Z:     res_z_ff     <= sum35[31:0];
                  FLD_ROLL:  res_roll_ff  <= sum35[15:0];
                  FLD_PITCH: res_pitch_ff <= sum35[15:0];
                  default:   res_yaw_ff   <= sum35[15:0];
               endcase
            end
            default: ;
         endcase
      end
      // stored pose returned as is
      if (cmd.slot_latch) begin
         res_x_ff     <= rd_x_ff;
         res_y_ff     <= rd_y_ff;
         res_z_ff     <= rd_z_ff;
         res_roll_ff  <= rd_a_ff[15:0];
         res_pitch_ff <= rd_a_ff[31:16];
         res_yaw_ff   <= rd_a_ff[47:32];
         res_held_ff  <= 1'b1;
      end
   end

   // output register
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_x       <= res_x_ff;
         rsp_out_y       <= res_y_ff;
         rsp_out_z       <= res_z_ff;
         rsp_out_roll    <= res_roll_ff;
         rsp_out_pitch   <= res_pitch_ff;
         rsp_out_yaw     <= res_yaw_ff;
         rsp_held_at_end <= res_held_ff;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   // status to controller
   always_comb begin
      status.req_mode  = req_mode;
      status.rate_pass = (period_ff == 32'd0) || !(gap < signed'(34'(period_ff)));
      status.n_is_one  = n_full == 32'd1;
      status.loop_on   = loop_ff;
      status.past_end  = now_ff >= end_ff;
      status.hit       = t_ff <= signed'(rd_t_ff);
      status.el_le0    = el_le0_ff;
      status.el_ge_dur = el_ge_ff;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

FILE: src/keyframe_pose_interpolator.sv
// Keyframe pose interpolator top level. A load beat or a dropped query gives no result.
// A query returns the single waypoint, holds the last one past the end, holds the last
// one on a search miss, or interpolates after a search of the table and a per-field
// multiply; the ratio divider runs inside a segment and the loop wrap adds a modulo divide.
// One item at a time; a result waiting on rsp_ready stalls the next. Sync reset clears
// control, config to defaults and the last-query time; tables are not cleared.
`default_nettype none
module keyframe_pose_interpolator
   import kpi_pkg::*;
#(
   parameter int MAX_WAYPOINTS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_mode,
   input  wire logic [5:0]         req_entry_index,
   input  wire logic signed [31:0] req_time_value,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [15:0] req_roll_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   input  wire logic signed [15:0] req_yaw_angle,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_out_x,
   output      logic signed [31:0] rsp_out_y,
   output      logic signed [31:0] rsp_out_z,
   output      logic signed [15:0] rsp_out_roll,
   output      logic signed [15:0] rsp_out_pitch,
   output      logic signed [15:0] rsp_out_yaw,
   output      logic               rsp_held_at_end,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int AW = $clog2(MAX_WAYPOINTS);

   kpi_cmd_type    cmd;
   kpi_status_type status;
   logic [AW-1:0]  rd_addr, last_idx;

   // config writes always taken
   assign csr_ready = 1'b1;

   kpi_ctrl #(.AW(AW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .last_idx  (last_idx),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   kpi_datapath #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .AW(AW)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status),
      .last_idx        (last_idx),
      .csr_fire        (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_time_value  (req_time_value),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_roll_angle  (req_roll_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_yaw_angle   (req_yaw_angle),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_roll    (rsp_out_roll),
      .rsp_out_pitch   (rsp_out_pitch),
      .rsp_out_yaw     (rsp_out_yaw),
      .rsp_held_at_end (rsp_held_at_end)
   );

endmodule
`default_nettype wire
